FILE: design/bf3_pkg.sv
// Shared constants, types and register codes of the 3x3 box filter stream.
package bf3_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned PixW      = 16;
  localparam int unsigned CoordW    = 10;
  localparam int unsigned AddrW     = $clog2(MaxWidth);
  localparam int unsigned SizeW     = 11;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned Sum3W     = PixW + 2;
  localparam int unsigned Sum9W     = PixW + 4;
  localparam int unsigned ProdW     = Sum9W + CoefW;
  localparam int unsigned FracW     = 16;
  localparam int unsigned WinCols   = 3;
  localparam int unsigned NumSlots  = 3;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [PixW-1:0]  PixMax      = {PixW{1'b1}};
  localparam logic [SizeW-1:0] WidthReset  = SizeW'(10);
  localparam logic [SizeW-1:0] HeightReset = SizeW'(50);
  localparam logic [CoefW-1:0] CoefReset   = CoefW'(7209);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_COEF   = 2'd2
  } cfg_idx_e;

  // one window column, top row to bottom row
  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] bot;
  } col_t;

  // one result pixel
  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [PixW-1:0]   val;
  } result_t;

  // the results of one input, slot 0 goes out first
  typedef struct packed {
    result_t [NumSlots-1:0] slot;
    logic [NumSlots-1:0]    mask;
  } emit_t;

  // per-pixel bookkeeping travelling down the pipeline
  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] col_last;
    logic [PixW-1:0]   pix;
    logic [PixW-1:0]   mid;
    logic [PixW-1:0]   center;
    logic              en_diag;
    logic              en_edge;
    logic              en_self;
    logic              interior;
  } meta_t;

endpackage

FILE: design/box_filter_3x3_stream.sv
// Top level of the 3x3 box filter over a raster pixel stream.
//
// Pixels enter on the s_axis channel in raster order, one request per pixel;
// the frame position is counted inside. Results leave on m_axis as
// (row, column, value); each input gives zero to three results, the last of
// them marked by tlast. Every frame pixel is sent exactly once: interior
// pixels are the rounded, saturated weighted sum of their 3x3 neighbourhood,
// border pixels go out unchanged.
// The first result of an input is offered once the input has passed pipeline
// stages 1 to 4 and been loaded into the output register.
// Throughput: one pixel per cycle while the output stage is free; an input
// with several results holds the single output register until all are sent.
// The cfg channel (always ready) writes width, height and the kernel weight;
// write it only while the block is idle.
// Reset clears the counters, window cells and pipeline; line buffers hold
// stale data, which never reaches a result within a frame. When the receiver
// stalls, the four-stage pipeline keeps filling behind the output stage and
// then drops s_axis_tready_o.
module box_filter_3x3_stream (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [bf3_pkg::PixW-1:0]     s_axis_tdata_i,   // [15:0] pixel_in
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [9:0] out_row, [19:10] out_col, [35:20] filtered_value, [39:36] zero
  output logic [bf3_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                         m_axis_tlast_o,   // run_last
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bf3_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bf3_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CoordW = bf3_pkg::CoordW;
  localparam int unsigned SizeW  = bf3_pkg::SizeW;
  localparam int unsigned PixW   = bf3_pkg::PixW;

  logic [SizeW-1:0]          width_q, height_q;
  logic [bf3_pkg::CoefW-1:0] coef_q;
  logic [CoordW-1:0]         row_q, row_d, col_q, col_d;
  logic [CoordW-1:0]         wm1, hm1, rc, cc;
  logic                      adv, accept, emit_free, emit_load;
  logic                      v1_q, v2_q, v3_q, v4_q;
  bf3_pkg::meta_t            meta0, meta1_q, meta2_q, meta3_q, meta4_q;
  bf3_pkg::meta_t            meta1_fwd, meta2_fwd;
  logic [PixW-1:0]           up_rd, mid_rd;
  logic [bf3_pkg::Sum9W-1:0] total_q;
  logic [bf3_pkg::ProdW-1:0] prod_q;
  logic [bf3_pkg::ProdW:0]   rnd;
  logic [PixW-1:0]           filt;
  bf3_pkg::emit_t            emit;
  bf3_pkg::col_t             new_col;
  logic [bf3_pkg::Sum3W-1:0] new_sum;
  bf3_pkg::col_t             chain_col [bf3_pkg::WinCols+1];
  logic [bf3_pkg::Sum3W-1:0] chain_sum [bf3_pkg::WinCols+1];
  logic                      win_step;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bf3_pkg::WidthReset;
      height_q <= bf3_pkg::HeightReset;
      coef_q   <= bf3_pkg::CoefReset;
    end else if (cfg_valid_i) begin
      unique case (bf3_pkg::cfg_idx_e'(cfg_index_i))
        bf3_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[SizeW-1:0];
        bf3_pkg::CFG_HEIGHT: height_q <= cfg_data_i[SizeW-1:0];
        bf3_pkg::CFG_COEF:   coef_q   <= cfg_data_i[bf3_pkg::CoefW-1:0];
        default: ;
      endcase
    end
  end

  // last column / row index with the sizes clamped to the supported range
  always_comb begin
    if (width_q < SizeW'(3)) begin
      wm1 = CoordW'(2);
    end else if (width_q > SizeW'(bf3_pkg::MaxWidth)) begin
      wm1 = CoordW'(bf3_pkg::MaxWidth - 1);
    end else begin
      wm1 = CoordW'(width_q - SizeW'(1));
    end
    if (height_q < SizeW'(3)) begin
      hm1 = CoordW'(2);
    end else if (height_q > SizeW'(bf3_pkg::MaxHeight)) begin
      hm1 = CoordW'(bf3_pkg::MaxHeight - 1);
    end else begin
      hm1 = CoordW'(height_q - SizeW'(1));
    end
  end

  // pipeline moves unless the last stage is held by a busy output stage
  assign adv             = !v4_q || emit_free;
  assign s_axis_tready_o = adv;
  assign accept          = s_axis_tvalid_i && adv;

  // frame position and the results this pixel will cause
  always_comb begin
    rc = (row_q > hm1) ? hm1 : row_q;
    cc = (col_q > wm1) ? wm1 : col_q;
    if (cc >= wm1) begin
      col_d = '0;
      row_d = (rc >= hm1) ? '0 : rc + CoordW'(1);
    end else begin
      col_d = cc + CoordW'(1);
      row_d = rc;
    end
    meta0          = '0;
    meta0.row      = rc;
    meta0.col      = cc;
    meta0.col_last = wm1;
    meta0.pix      = s_axis_tdata_i;
    meta0.en_diag  = (rc != '0) && (cc != '0);
    meta0.en_edge  = (rc != '0) && (cc == wm1);
    meta0.en_self  = (rc == hm1);
    meta0.interior = (rc >= CoordW'(2)) && (cc >= CoordW'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // line buffers: middle written on entry, upper gets the old middle as the pixel leaves stage 1
  assign win_step = adv && v1_q;

  bf3_line_ram u_upper (
    .clk_i   (clk_i),
    .we_i    (win_step),
    .waddr_i (meta1_q.col),
    .wdata_i (mid_rd),
    .re_i    (accept),
    .raddr_i (cc),
    .rdata_o (up_rd)
  );

  bf3_line_ram u_middle (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (cc),
    .wdata_i (s_axis_tdata_i),
    .re_i    (accept),
    .raddr_i (cc),
    .rdata_o (mid_rd)
  );

  // window: newest column enters the right cell and shifts left
  assign new_col.top = up_rd;
  assign new_col.mid = mid_rd;
  assign new_col.bot = meta1_q.pix;
  assign new_sum     = bf3_pkg::Sum3W'(up_rd) + bf3_pkg::Sum3W'(mid_rd)
                     + bf3_pkg::Sum3W'(meta1_q.pix);
  assign chain_col[bf3_pkg::WinCols] = new_col;
  assign chain_sum[bf3_pkg::WinCols] = new_sum;

  for (genvar gi = 0; gi < bf3_pkg::WinCols; gi++) begin : g_cell
    bf3_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (win_step),
      .col_i  (chain_col[gi+1]),
      .sum_i  (chain_sum[gi+1]),
      .col_o  (chain_col[gi]),
      .sum_o  (chain_sum[gi])
    );
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage payloads with the middle-row pixel and the window centre filled in
  always_comb begin
    meta1_fwd        = meta1_q;
    meta1_fwd.mid    = mid_rd;
    meta2_fwd        = meta2_q;
    meta2_fwd.center = chain_col[1].mid;
  end

  // pipeline payload: read, window sum, multiply
  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta1_q <= meta0;
      meta2_q <= meta1_fwd;
      meta3_q <= meta2_fwd;
      meta4_q <= meta3_q;
      total_q <= bf3_pkg::Sum9W'(chain_sum[0]) + bf3_pkg::Sum9W'(chain_sum[1])
               + bf3_pkg::Sum9W'(chain_sum[2]);
      prod_q  <= bf3_pkg::ProdW'(total_q) * bf3_pkg::ProdW'(coef_q);
    end
  end

  // round to nearest, saturate, and build the result slots
  always_comb begin
    rnd  = ((bf3_pkg::ProdW+1)'(prod_q) + (bf3_pkg::ProdW+1)'(32768))
           >> bf3_pkg::FracW;
    filt = (rnd > (bf3_pkg::ProdW+1)'(bf3_pkg::PixMax)) ? bf3_pkg::PixMax : rnd[PixW-1:0];
    emit.slot[0].row = meta4_q.row - CoordW'(1);
    emit.slot[0].col = meta4_q.col - CoordW'(1);
    emit.slot[0].val = meta4_q.interior ? filt : meta4_q.center;
    emit.slot[1].row = meta4_q.row - CoordW'(1);
    emit.slot[1].col = meta4_q.col_last;
    emit.slot[1].val = meta4_q.mid;
    emit.slot[2].row = meta4_q.row;
    emit.slot[2].col = meta4_q.col;
    emit.slot[2].val = meta4_q.pix;
    emit.mask        = {meta4_q.en_self, meta4_q.en_edge, meta4_q.en_diag};
  end

  assign emit_load = adv && v4_q;

  bf3_emitter u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (emit_load),
    .load_data_i     (emit),
    .free_o          (emit_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // the output stage is only loaded when it has sent everything it held
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |-> emit_free)
    else $error("output stage overwritten while results pending");

  // the delayed upper-buffer write never meets the read of a new pixel
  a_upper_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_step && accept) |-> (meta1_q.col != cc))
    else $error("upper line buffer read and write at the same column");

  // an accepted pixel is in the first stage on the next edge
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted pixel lost at pipeline entry");

  // the window moves only while a pixel leaves the first stage
  a_window_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !win_step |=> ($stable(chain_sum[0]) && $stable(chain_sum[2])))
    else $error("window shifted without a pixel");

endmodule

FILE: design/bf3_line_ram.sv
// Line buffer memory: one write port, one registered read port.
module bf3_line_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [bf3_pkg::AddrW-1:0] waddr_i,
  input  logic [bf3_pkg::PixW-1:0]  wdata_i,
  input  logic                     re_i,
  input  logic [bf3_pkg::AddrW-1:0] raddr_i,
  output logic [bf3_pkg::PixW-1:0]  rdata_o
);

  logic [bf3_pkg::PixW-1:0] mem_q [bf3_pkg::MaxWidth];
  logic [bf3_pkg::PixW-1:0] rdata_q;

  // read returns the old entry on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bf3_cell.sv
// One window column cell: holds a pixel column and its sum, hands both on.
module bf3_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  bf3_pkg::col_t             col_i,
  input  logic [bf3_pkg::Sum3W-1:0] sum_i,
  output bf3_pkg::col_t             col_o,
  output logic [bf3_pkg::Sum3W-1:0] sum_o
);

  bf3_pkg::col_t             col_q;
  logic [bf3_pkg::Sum3W-1:0] sum_q;

  // shift in the neighbour's column on each window step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      sum_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
      sum_q <= sum_i;
    end
  end

  assign col_o = col_q;
  assign sum_o = sum_q;

endmodule

FILE: design/bf3_emitter.sv
// Output stage: holds up to three results of one pixel and sends them in order.
module bf3_emitter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  bf3_pkg::emit_t               load_data_i,
  output logic                         free_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [bf3_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);

  logic [bf3_pkg::NumSlots-1:0] mask_q, mask_d, rest;
  bf3_pkg::result_t [bf3_pkg::NumSlots-1:0] slot_q;
  bf3_pkg::result_t cur;
  logic hs, last;

  // pending results, lowest slot first
  always_comb begin
    rest = mask_q & (mask_q - bf3_pkg::NumSlots'(1));
    last = (rest == '0);
    hs   = m_axis_tvalid_o && m_axis_tready_i;
    free_o = (mask_q == '0) || (hs && last);
    mask_d = mask_q;
    if (hs) begin
      mask_d = rest;
    end
    if (load_i) begin
      mask_d = load_data_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= load_data_i.slot;
    end
  end

  // pick the first pending slot
  always_comb begin
    if (mask_q[0]) begin
      cur = slot_q[0];
    end else if (mask_q[1]) begin
      cur = slot_q[1];
    end else begin
      cur = slot_q[2];
    end
  end

  assign m_axis_tvalid_o = (mask_q != '0);
  assign m_axis_tlast_o  = last;
  assign m_axis_tdata_o  = {4'd0, cur.val, cur.col, cur.row};

endmodule
